>>> src/ist_pkg.sv
// ---------------------------------------------------------------------------
// ist_pkg
// Shared types, latencies and saturating Q16.16 helpers for the
// isothermal two-shock flux core.
// ---------------------------------------------------------------------------
package ist_pkg;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    localparam logic [30:0] SOUND_SPEED_RST = 31'd65536;

    // divider: prep + 31 quotient bits + output stage
    localparam int DIV_LAT  = 33;
    // square root: prep + 24 root bits
    localparam int SQRT_LAT = 25;
    localparam int SQRT_PAD = DIV_LAT - SQRT_LAT;

    // values carried alongside one item through the whole pipeline
    typedef struct packed {
        q_t   dl;
        q_t   dr;
        q_t   mxl;
        q_t   myl;
        q_t   mzl;
        q_t   mxr;
        q_t   myr;
        q_t   mzr;
        q_t   vxl;
        q_t   vyl;
        q_t   vzl;
        q_t   vxr;
        q_t   vyr;
        q_t   vzr;
        q_t   zl;
        q_t   zr;
        q_t   s;
        q_t   p;
        q_t   dz;
        q_t   dv;
        q_t   n1;
        q_t   d1;
        q_t   tmp;
        q_t   t2;
        q_t   u;
        q_t   qr;
        q_t   e;
        q_t   zcp;
        q_t   zcn;
        q_t   zc;
        q_t   mc;
        q_t   dc;
        q_t   mvl;
        q_t   mvr;
        q_t   cdz;
        q_t   sumv;
        q_t   a1;
        q_t   a2;
        q_t   w1;
        q_t   w2;
        q_t   sl;
        q_t   sr;
        q_t   vxc;
        logic bad;
    } ist_ctx_t;

    localparam int CTX_W = $bits(ist_ctx_t);

    function automatic q_t qsat64(input logic signed [63:0] v);
        if (v[63:31] == {33{v[63]}}) begin
            return q_t'(v[31:0]);
        end
        return v[63] ? Q_MIN : Q_MAX;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [63:0] t;
        t = 64'(a) + 64'(b);
        return qsat64(t);
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic signed [63:0] t;
        t = 64'(a) - 64'(b);
        return qsat64(t);
    endfunction

    // product >>> 16 rounds toward minus infinity
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return qsat64(p >>> 16);
    endfunction

    function automatic q_t sat_twice(input logic [30:0] c);
        return c[30] ? Q_MAX : q_t'({c, 1'b0});
    endfunction

endpackage

>>> src/ist_dly.sv
// ---------------------------------------------------------------------------
// ist_dly
// Enabled delay line carrying a valid bit and a payload word.
// ---------------------------------------------------------------------------
module ist_dly #(
    parameter int W     = 32,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         vld_i,
    input  logic [W-1:0] dat_i,
    output logic         vld_o,
    output logic [W-1:0] dat_o
);

    logic [DEPTH-1:0] vld_reg;
    logic [W-1:0]     dat_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg[0] <= vld_i;
            for (int k = 1; k < DEPTH; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dat_reg[0] <= dat_i;
            for (int k = 1; k < DEPTH; k++) begin
                dat_reg[k] <= dat_reg[k-1];
            end
        end
    end

    assign vld_o = vld_reg[DEPTH-1];
    assign dat_o = dat_reg[DEPTH-1];

endmodule

>>> src/ist_div.sv
// ---------------------------------------------------------------------------
// ist_div
// Pipelined signed Q16.16 divider, one quotient bit per stage:
// quo = sat((num * 2^16) / den), truncated toward zero.
// ---------------------------------------------------------------------------
module ist_div (
    input  logic        aclk,
    input  logic        en,
    input  ist_pkg::q_t num,
    input  ist_pkg::q_t den,
    output ist_pkg::q_t quo
);
    import ist_pkg::*;

    localparam int STEPS = 31;

    logic [31:0] ua;
    logic [31:0] ud;
    logic [31:0] a_mag;
    logic [31:0] d_mag;
    logic        ovf;

    logic [31:0] rem_reg  [STEPS+1];
    logic [30:0] nlo_reg  [STEPS+1];
    logic [31:0] dm_reg   [STEPS+1];
    logic [30:0] qb_reg   [STEPS+1];
    logic        neg_reg  [STEPS+1];
    logic        sat_reg  [STEPS+1];
    logic        zero_reg [STEPS+1];
    q_t          quo_reg;
    q_t          quo_next;
    logic [31:0] qm;

    assign ua    = num;
    assign ud    = den;
    assign a_mag = ua[31] ? (~ua + 32'd1) : ua;
    assign d_mag = ud[31] ? (~ud + 32'd1) : ud;
    // quotient magnitude reaches 2^31 (also covers a zero divisor)
    assign ovf   = {15'b0, a_mag} >= {d_mag, 15'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {15'b0, a_mag[31:15]};
            nlo_reg[0]  <= {a_mag[14:0], 16'b0};
            dm_reg[0]   <= d_mag;
            qb_reg[0]   <= '0;
            neg_reg[0]  <= num[31] ^ den[31];
            sat_reg[0]  <= ovf;
            zero_reg[0] <= (num == '0);
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int BI = STEPS - 1 - k;
        logic [32:0] t;
        logic        ge;
        logic [30:0] qb_next;

        assign t  = {rem_reg[k], nlo_reg[k][BI]};
        assign ge = t >= {1'b0, dm_reg[k]};

        always_comb begin
            qb_next     = qb_reg[k];
            qb_next[BI] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? 32'(t - {1'b0, dm_reg[k]}) : t[31:0];
                nlo_reg[k+1]  <= nlo_reg[k];
                dm_reg[k+1]   <= dm_reg[k];
                qb_reg[k+1]   <= qb_next;
                neg_reg[k+1]  <= neg_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    assign qm = {1'b0, qb_reg[STEPS]};

    always_comb begin
        if (zero_reg[STEPS]) begin
            quo_next = '0;
        end else if (sat_reg[STEPS]) begin
            quo_next = neg_reg[STEPS] ? Q_MIN : Q_MAX;
        end else begin
            quo_next = neg_reg[STEPS] ? q_t'(~qm + 32'd1) : q_t'(qm);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> src/ist_sqrt.sv
// ---------------------------------------------------------------------------
// ist_sqrt
// Pipelined Q16.16 square root, one root bit per stage:
// root = floor(sqrt(rad * 2^16)) for rad > 0, else zero.
// ---------------------------------------------------------------------------
module ist_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  ist_pkg::q_t rad,
    output ist_pkg::q_t root
);
    import ist_pkg::*;

    localparam int STEPS = 24;

    logic [47:0] x_reg    [STEPS+1];
    logic [25:0] rem_reg  [STEPS+1];
    logic [23:0] root_reg [STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= (!rad[31] && rad != '0) ? {rad, 16'b0} : '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int BI = STEPS - 1 - k;
        logic [26:0] r2;
        logic [26:0] trial;
        logic        ge;

        assign r2    = {rem_reg[k][24:0], x_reg[k][2*BI+1 -: 2]};
        assign trial = {1'b0, root_reg[k], 2'b01};
        assign ge    = r2 >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]    <= x_reg[k];
                rem_reg[k+1]  <= ge ? 26'(r2 - trial) : r2[25:0];
                root_reg[k+1] <= {root_reg[k][22:0], ge};
            end
        end
    end

    assign root = q_t'({8'b0, root_reg[STEPS]});

endmodule

>>> src/isothermal_two_shock_flux_core.sv
// ---------------------------------------------------------------------------
// isothermal_two_shock_flux_core
// Isothermal two-shock flux at one cell interface, signed Q16.16.
// ---------------------------------------------------------------------------
// Input stream (s_*): one request per interface, left then right state
// (density, x/y/z momentum per side) packed in s_tdata.
// Output stream (m_*): four saturated fluxes in m_tdata, bad-density flag
// in m_tuser; fluxes read zero when the flag is set.
// Config: cfg_wr_en/cfg_wr_data load the sound speed (reset 1.0); write it
// only with the pipeline empty.
// Throughput: one request per cycle while the output is not held. The
// path from accept to m_tvalid runs through four chained 33-stage
// dividers, one 25-stage square root and twelve arithmetic stages.
// All stages share one enable: when the output is held and m_tready is
// low, the whole pipeline freezes and s_tready drops; nothing is lost.
// Reset clears all valid bits and reloads the sound speed.
// ---------------------------------------------------------------------------
module isothermal_two_shock_flux_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [30:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_density, left_mom_x/y/z, right_density, right_mom_x/y/z
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mass_flux, xmom_flux, ymom_flux, zmom_flux
    output logic [127:0] m_tdata,
    // bad_density
    output logic         m_tuser
);
    import ist_pkg::*;

    typedef struct packed {
        q_t   p1;
        q_t   p2;
        q_t   p3;
        q_t   p4;
        q_t   f0u;
        q_t   vxc;
        q_t   vys;
        q_t   vzs;
        logic star;
        logic bad;
    } r10_t;

    typedef struct packed {
        q_t   f0;
        q_t   f1a;
        q_t   p2;
        q_t   f2;
        q_t   f3;
        logic bad;
    } r11_t;

    logic        adv;
    logic [30:0] sound_speed_reg;
    q_t          c_q;
    q_t          c2_reg;
    q_t          c2x_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign c_q      = q_t'({1'b0, sound_speed_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_speed_reg <= SOUND_SPEED_RST;
        end else if (cfg_wr_en) begin
            sound_speed_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        c2_reg  <= qmul(c_q, c_q);
        c2x_reg <= sat_twice(sound_speed_reg);
    end

    // ---------------- velocities and density roots ----------------
    ist_ctx_t ctx_in;
    ist_ctx_t a0_ctx;
    ist_ctx_t a1_in;
    ist_ctx_t a1_ctx;
    ist_ctx_t a_ctx;
    logic     a0_vld;
    logic     a_vld;
    q_t       va_num [6];
    q_t       va_den [6];
    q_t       va_quo [6];
    q_t       zl_w;
    q_t       zr_w;

    always_comb begin
        ctx_in     = '0;
        ctx_in.dl  = q_t'(s_tdata[31:0]);
        ctx_in.mxl = q_t'(s_tdata[63:32]);
        ctx_in.myl = q_t'(s_tdata[95:64]);
        ctx_in.mzl = q_t'(s_tdata[127:96]);
        ctx_in.dr  = q_t'(s_tdata[159:128]);
        ctx_in.mxr = q_t'(s_tdata[191:160]);
        ctx_in.myr = q_t'(s_tdata[223:192]);
        ctx_in.mzr = q_t'(s_tdata[255:224]);
        ctx_in.bad = ctx_in.dl[31] || ctx_in.dl == '0 ||
                     ctx_in.dr[31] || ctx_in.dr == '0;
    end

    assign va_num[0] = ctx_in.mxl;
    assign va_num[1] = ctx_in.myl;
    assign va_num[2] = ctx_in.mzl;
    assign va_num[3] = ctx_in.mxr;
    assign va_num[4] = ctx_in.myr;
    assign va_num[5] = ctx_in.mzr;
    assign va_den[0] = ctx_in.dl;
    assign va_den[1] = ctx_in.dl;
    assign va_den[2] = ctx_in.dl;
    assign va_den[3] = ctx_in.dr;
    assign va_den[4] = ctx_in.dr;
    assign va_den[5] = ctx_in.dr;

    for (genvar g = 0; g < 6; g++) begin : g_vdiv
        ist_div u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (va_num[g]),
            .den  (va_den[g]),
            .quo  (va_quo[g])
        );
    end

    ist_sqrt u_sqrt_l (.aclk(aclk), .en(adv), .rad(ctx_in.dl), .root(zl_w));
    ist_sqrt u_sqrt_r (.aclk(aclk), .en(adv), .rad(ctx_in.dr), .root(zr_w));

    ist_dly #(.W(CTX_W), .DEPTH(SQRT_LAT)) u_dly_a0 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_i(s_tvalid), .dat_i(ctx_in), .vld_o(a0_vld), .dat_o(a0_ctx)
    );

    always_comb begin
        a1_in    = a0_ctx;
        a1_in.zl = zl_w;
        a1_in.zr = zr_w;
    end

    ist_dly #(.W(CTX_W), .DEPTH(SQRT_PAD)) u_dly_a1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_i(a0_vld), .dat_i(a1_in), .vld_o(a_vld), .dat_o(a1_ctx)
    );

    always_comb begin
        a_ctx     = a1_ctx;
        a_ctx.vxl = va_quo[0];
        a_ctx.vyl = va_quo[1];
        a_ctx.vzl = va_quo[2];
        a_ctx.vxr = va_quo[3];
        a_ctx.vyr = va_quo[4];
        a_ctx.vzr = va_quo[5];
    end

    // ---------------- tmp = p*(vxl-vxr) / (2c*s) ----------------
    ist_ctx_t r1_reg, r1_next, r2_reg, r2_next, b_ctx;
    logic     r1_vld_reg, r2_vld_reg, b_vld;
    q_t       tmp_w;

    always_comb begin
        r1_next    = a_ctx;
        r1_next.s  = qadd(a_ctx.zl, a_ctx.zr);
        r1_next.p  = qmul(a_ctx.zl, a_ctx.zr);
        r1_next.dz = qsub(a_ctx.zl, a_ctx.zr);
        r1_next.dv = qsub(a_ctx.vxl, a_ctx.vxr);
    end

    always_comb begin
        r2_next    = r1_reg;
        r2_next.n1 = qmul(r1_reg.p, r1_reg.dv);
        r2_next.d1 = qmul(c2x_reg, r1_reg.s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end else if (adv) begin
            r1_vld_reg <= a_vld;
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
    end

    ist_div u_div_tmp (
        .aclk(aclk), .en(adv), .num(r2_reg.n1), .den(r2_reg.d1), .quo(tmp_w)
    );

    ist_dly #(.W(CTX_W), .DEPTH(DIV_LAT)) u_dly_b (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_i(r2_vld_reg), .dat_i(r2_reg), .vld_o(b_vld), .dat_o(b_ctx)
    );

    // ---------------- q = sqrt(tmp^2 + p) ----------------
    ist_ctx_t r3_reg, r3_next, r4_reg, r4_next, c_ctx;
    logic     r3_vld_reg, r4_vld_reg, c_vld;
    q_t       q_w;

    always_comb begin
        r3_next     = b_ctx;
        r3_next.tmp = tmp_w;
        r3_next.t2  = qmul(tmp_w, tmp_w);
    end

    always_comb begin
        r4_next   = r3_reg;
        r4_next.u = qadd(r3_reg.t2, r3_reg.p);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r3_vld_reg <= 1'b0;
            r4_vld_reg <= 1'b0;
        end else if (adv) begin
            r3_vld_reg <= b_vld;
            r4_vld_reg <= r3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r3_reg <= r3_next;
            r4_reg <= r4_next;
        end
    end

    ist_sqrt u_sqrt_q (.aclk(aclk), .en(adv), .rad(r4_reg.u), .root(q_w));

    ist_dly #(.W(CTX_W), .DEPTH(SQRT_LAT)) u_dly_c (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_i(r4_vld_reg), .dat_i(r4_reg), .vld_o(c_vld), .dat_o(c_ctx)
    );

    // ---------------- zc, cancellation-free branch for tmp < 0 ----------------
    ist_ctx_t r5_reg, r5_next, d_ctx;
    logic     r5_vld_reg, d_vld;
    q_t       zcn_w;

    always_comb begin
        r5_next     = c_ctx;
        r5_next.qr  = q_w;
        r5_next.e   = qsub(q_w, c_ctx.tmp);
        r5_next.zcp = qadd(c_ctx.tmp, q_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r5_vld_reg <= 1'b0;
        end else if (adv) begin
            r5_vld_reg <= c_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r5_reg <= r5_next;
        end
    end

    ist_div u_div_zc (
        .aclk(aclk), .en(adv), .num(r5_reg.p), .den(r5_reg.e), .quo(zcn_w)
    );

    ist_dly #(.W(CTX_W), .DEPTH(DIV_LAT)) u_dly_d (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_i(r5_vld_reg), .dat_i(r5_reg), .vld_o(d_vld), .dat_o(d_ctx)
    );

    // ---------------- wave speeds and star velocity terms ----------------
    ist_ctx_t r6_reg, r6_next, r7_reg, r7_next, r8_reg, r8_next, e_ctx;
    logic     r6_vld_reg, r7_vld_reg, r8_vld_reg, e_vld;
    q_t       a1_w, a2_w, w1_w, w2_w;

    always_comb begin
        r6_next     = d_ctx;
        r6_next.zcn = zcn_w;
        r6_next.zc  = d_ctx.tmp[31] ? zcn_w : d_ctx.zcp;
    end

    always_comb begin
        r7_next     = r6_reg;
        r7_next.mc  = qmul(c_q, r6_reg.zc);
        r7_next.dc  = qmul(r6_reg.zc, r6_reg.zc);
        r7_next.mvl = qmul(r6_reg.vxl, r6_reg.zl);
        r7_next.mvr = qmul(r6_reg.vxr, r6_reg.zr);
        r7_next.cdz = qmul(c_q, r6_reg.dz);
    end

    always_comb begin
        r8_next      = r7_reg;
        r8_next.sumv = qadd(r7_reg.mvl, r7_reg.mvr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r6_vld_reg <= 1'b0;
            r7_vld_reg <= 1'b0;
            r8_vld_reg <= 1'b0;
        end else if (adv) begin
            r6_vld_reg <= d_vld;
            r7_vld_reg <= r6_vld_reg;
            r8_vld_reg <= r7_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r6_reg <= r6_next;
            r7_reg <= r7_next;
            r8_reg <= r8_next;
        end
    end

    ist_div u_div_a1 (
        .aclk(aclk), .en(adv), .num(r8_reg.mc), .den(r8_reg.zl), .quo(a1_w)
    );
    ist_div u_div_a2 (
        .aclk(aclk), .en(adv), .num(r8_reg.mc), .den(r8_reg.zr), .quo(a2_w)
    );
    ist_div u_div_w1 (
        .aclk(aclk), .en(adv), .num(r8_reg.sumv), .den(r8_reg.s), .quo(w1_w)
    );
    ist_div u_div_w2 (
        .aclk(aclk), .en(adv), .num(r8_reg.cdz), .den(r8_reg.zc), .quo(w2_w)
    );

    ist_dly #(.W(CTX_W), .DEPTH(DIV_LAT)) u_dly_e (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_i(r8_vld_reg), .dat_i(r8_reg), .vld_o(e_vld), .dat_o(e_ctx)
    );

    // ---------------- region select and fluxes ----------------
    ist_ctx_t r9_reg, r9_next;
    logic     r9_vld_reg, r10_vld_reg, r11_vld_reg, out_vld_reg;
    r10_t     r10_reg, r10_next;
    r11_t     r11_reg, r11_next;
    logic [127:0] out_data_reg, out_data_next;
    logic     out_bad_reg;
    logic     rgt, lft;
    q_t       op_a, op_b, op_d, op_my, op_mz, op_vx;

    always_comb begin
        r9_next     = e_ctx;
        r9_next.a1  = a1_w;
        r9_next.a2  = a2_w;
        r9_next.w1  = w1_w;
        r9_next.w2  = w2_w;
        r9_next.sl  = qsub(e_ctx.vxl, a1_w);
        r9_next.sr  = qadd(e_ctx.vxr, a2_w);
        r9_next.vxc = qadd(w1_w, w2_w);
    end

    // right upwind when sr <= 0, else left upwind when sl >= 0, else star
    assign rgt = r9_reg.sr[31] || r9_reg.sr == '0;
    assign lft = !rgt && !r9_reg.sl[31];

    always_comb begin
        op_vx = rgt ? r9_reg.vxr : r9_reg.vxl;
        op_my = rgt ? r9_reg.myr : r9_reg.myl;
        op_mz = rgt ? r9_reg.mzr : r9_reg.mzl;
        if (rgt) begin
            op_a = r9_reg.mxr;
            op_b = r9_reg.vxr;
            op_d = r9_reg.dr;
        end else if (lft) begin
            op_a = r9_reg.mxl;
            op_b = r9_reg.vxl;
            op_d = r9_reg.dl;
        end else begin
            op_a = r9_reg.dc;
            op_b = r9_reg.vxc;
            op_d = r9_reg.dc;
        end
        r10_next.p1   = qmul(op_a, op_b);
        r10_next.p2   = qmul(op_d, c2_reg);
        r10_next.p3   = qmul(op_my, op_vx);
        r10_next.p4   = qmul(op_mz, op_vx);
        r10_next.f0u  = rgt ? r9_reg.mxr : r9_reg.mxl;
        r10_next.vxc  = r9_reg.vxc;
        r10_next.vys  = r9_reg.vxc[31] ? r9_reg.vyr : r9_reg.vyl;
        r10_next.vzs  = r9_reg.vxc[31] ? r9_reg.vzr : r9_reg.vzl;
        r10_next.star = !rgt && !lft;
        r10_next.bad  = r9_reg.bad;
    end

    always_comb begin
        if (r10_reg.star) begin
            r11_next.f0  = r10_reg.p1;
            r11_next.f1a = qmul(r10_reg.p1, r10_reg.vxc);
            r11_next.f2  = qmul(r10_reg.p1, r10_reg.vys);
            r11_next.f3  = qmul(r10_reg.p1, r10_reg.vzs);
        end else begin
            r11_next.f0  = r10_reg.f0u;
            r11_next.f1a = r10_reg.p1;
            r11_next.f2  = r10_reg.p3;
            r11_next.f3  = r10_reg.p4;
        end
        r11_next.p2  = r10_reg.p2;
        r11_next.bad = r10_reg.bad;
    end

    always_comb begin
        if (r11_reg.bad) begin
            out_data_next = '0;
        end else begin
            out_data_next = {r11_reg.f3, r11_reg.f2,
                             qadd(r11_reg.f1a, r11_reg.p2), r11_reg.f0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r9_vld_reg  <= 1'b0;
            r10_vld_reg <= 1'b0;
            r11_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            r9_vld_reg  <= e_vld;
            r10_vld_reg <= r9_vld_reg;
            r11_vld_reg <= r10_vld_reg;
            out_vld_reg <= r11_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r9_reg       <= r9_next;
            r10_reg      <= r10_next;
            r11_reg      <= r11_next;
            out_data_reg <= out_data_next;
            out_bad_reg  <= r11_reg.bad;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule
